// ----- hdl/acbc_pkg.sv -----
// ----------------------------------------------------------------------------
// acbc_pkg: shared types and functions for the AES-256 CBC encrypt unit
// Holds the S-box table, the round functions and the queue entry type.
// ----------------------------------------------------------------------------
`default_nettype none

package acbc_pkg;

	localparam int unsigned ROUNDS    = 14;
	localparam int unsigned BLK_BYTES = 16;

	// configuration register indexes
	localparam logic [2:0] REG_KEY0    = 3'd0;
	localparam logic [2:0] REG_KEY1    = 3'd1;
	localparam logic [2:0] REG_KEY2    = 3'd2;
	localparam logic [2:0] REG_KEY3    = 3'd3;
	localparam logic [2:0] REG_IV_HIGH = 3'd4;
	localparam logic [2:0] REG_IV_LOW  = 3'd5;

	// one block waiting for the round engine
	typedef struct packed {
		logic [127:0] data;
		logic         first;
		logic         last;
	} acbc_entry_t;

	typedef enum logic [1:0] {
		ENG_IDLE,
		ENG_RUN,
		ENG_DONE
	} acbc_eng_state_t;

	// byte 0 in the top bits
	localparam logic [2047:0] SBOX_TABLE = {
		128'h637c777bf26b6fc53001672bfed7ab76,
		128'hca82c97dfa5947f0add4a2af9ca472c0,
		128'hb7fd9326363ff7cc34a5e5f171d83115,
		128'h04c723c31896059a071280e2eb27b275,
		128'h09832c1a1b6e5aa0523bd6b329e32f84,
		128'h53d100ed20fcb15b6acbbe394a4c58cf,
		128'hd0efaafb434d338545f9027f503c9fa8,
		128'h51a3408f929d38f5bcb6da2110fff3d2,
		128'hcd0c13ec5f974417c4a77e3d645d1973,
		128'h60814fdc222a908846eeb814de5e0bdb,
		128'he0323a0a4906245cc2d3ac629195e479,
		128'he7c8376d8dd54ea96c56f4ea657aae08,
		128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
		128'h703eb5664803f60e613557b986c11d9e,
		128'he1f8981169d98e949b1e87e9ce5528df,
		128'h8ca1890dbfe6426841992d0fb054bb16
	};

	function automatic logic [7:0] sbox(input logic [7:0] x);
		logic [10:0] pos;
		pos = {~x, 3'b000};
		return SBOX_TABLE[pos +: 8];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
	endfunction

	// SubBytes and ShiftRows; byte j sits at bits (15-j)*8
	function automatic logic [127:0] sub_shift(input logic [127:0] s);
		logic [127:0] t;
		int unsigned  src;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				src = r + 4 * ((c + r) % 4);
				t[(15 - (r + 4 * c)) * 8 +: 8] = sbox(s[(15 - src) * 8 +: 8]);
			end
		end
		return t;
	endfunction

	function automatic logic [127:0] mix_cols(input logic [127:0] s);
		logic [127:0] t;
		logic [7:0]   a0, a1, a2, a3, all;
		for (int c = 0; c < 4; c++) begin
			a0  = s[(15 - 4 * c) * 8 +: 8];
			a1  = s[(14 - 4 * c) * 8 +: 8];
			a2  = s[(13 - 4 * c) * 8 +: 8];
			a3  = s[(12 - 4 * c) * 8 +: 8];
			all = a0 ^ a1 ^ a2 ^ a3;
			t[(15 - 4 * c) * 8 +: 8] = a0 ^ all ^ xtime(a0 ^ a1);
			t[(14 - 4 * c) * 8 +: 8] = a1 ^ all ^ xtime(a1 ^ a2);
			t[(13 - 4 * c) * 8 +: 8] = a2 ^ all ^ xtime(a2 ^ a3);
			t[(12 - 4 * c) * 8 +: 8] = a3 ^ all ^ xtime(a3 ^ a0);
		end
		return t;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/aes256_cbc_encrypt_pkcs7_unit.sv -----
// ----------------------------------------------------------------------------
// aes256_cbc_encrypt_pkcs7_unit: AES-256 CBC encryption with PKCS#7 padding
// Front end pads and tags blocks, a queue decouples it from the round engine.
// ----------------------------------------------------------------------------
// Usage:
//  - Write the key (indexes 0..3) and IV (4, 5) through cfg_write/cfg_index/
//    cfg_data while the unit is idle. They are sampled at each message start.
//  - Input channel in_valid/in_ready transfers one 16-byte plaintext block.
//    final_block closes a message; valid_bytes (0..16, larger saturates)
//    counts its leading valid bytes. A full final block yields an extra
//    pad block of 0x10 bytes, and only that one carries message_end.
//  - Output channel out_valid/out_ready transfers one ciphertext block.
//  - Each block goes through engine load, 14 rounds and handoff before
//    out_valid. A new block enters the engine only after the last is handed
//    off; the single round unit and CBC chain feed each block into the next.
//  - A two-entry queue lets inputs transfer while the engine works; a
//    stalled receiver holds the output register, then the engine, then
//    the queue, and finally in_ready drops.
//  - Reset clears all control state; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module aes256_cbc_encrypt_pkcs7_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [63:0] plain_high,
	input  wire logic [63:0] plain_low,
	input  wire logic        final_block,
	input  wire logic [4:0]  valid_bytes,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      cipher_high,
	output logic [63:0]      cipher_low,
	output logic             message_end
);

	logic [63:0] key0_q, key1_q, key2_q, key3_q, ivh_q, ivl_q;

	logic                  push_valid, push_ready;
	acbc_pkg::acbc_entry_t push_entry;
	logic                  pop_valid, pop_ready;
	acbc_pkg::acbc_entry_t pop_entry;
	logic [127:0]          res;

	// configuration registers; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q <= '0;
			key1_q <= '0;
			key2_q <= '0;
			key3_q <= '0;
			ivh_q  <= '0;
			ivl_q  <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				acbc_pkg::REG_KEY0:    key0_q <= cfg_data;
				acbc_pkg::REG_KEY1:    key1_q <= cfg_data;
				acbc_pkg::REG_KEY2:    key2_q <= cfg_data;
				acbc_pkg::REG_KEY3:    key3_q <= cfg_data;
				acbc_pkg::REG_IV_HIGH: ivh_q  <= cfg_data;
				acbc_pkg::REG_IV_LOW:  ivl_q  <= cfg_data;
				default:  ;
			endcase
		end
	end

	acbc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.plain_high  (plain_high),
		.plain_low   (plain_low),
		.final_block (final_block),
		.valid_bytes (valid_bytes),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_entry  (push_entry)
	);

	acbc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	acbc_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (pop_valid),
		.q_ready   (pop_ready),
		.q_entry   (pop_entry),
		.key       ({key0_q, key1_q, key2_q, key3_q}),
		.iv        ({ivh_q, ivl_q}),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (res),
		.out_end   (message_end)
	);

	assign cipher_high = res[127:64];
	assign cipher_low  = res[63:0];

endmodule

`default_nettype wire

// ----- hdl/acbc_front.sv -----
// ----------------------------------------------------------------------------
// acbc_front: input side of the AES-256 CBC encrypt unit
// Takes plaintext blocks, applies PKCS#7 padding and marks message start.
// ----------------------------------------------------------------------------
`default_nettype none

module acbc_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [63:0]          plain_high,
	input  wire logic [63:0]          plain_low,
	input  wire logic                 final_block,
	input  wire logic [4:0]           valid_bytes,
	output logic                      push_valid,
	input  wire logic                 push_ready,
	output acbc_pkg::acbc_entry_t     push_entry
);

	logic         open_q;
	logic         pad_q;
	logic [4:0]   cnt;
	logic [7:0]   pad_byte;
	logic [127:0] blk;
	logic         take;

	assign cnt      = (valid_bytes > 5'd16) ? 5'd16 : valid_bytes;
	assign pad_byte = 8'd16 - {3'b000, cnt};
	assign in_ready = push_ready && !pad_q;
	assign take     = in_valid && in_ready;

	always_comb begin
		blk = {plain_high, plain_low};
		for (int j = 0; j < 16; j++) begin
			if (final_block && (5'(j) >= cnt)) begin
				blk[(15 - j) * 8 +: 8] = pad_byte;
			end
		end
	end

	always_comb begin
		if (pad_q) begin
			push_valid       = 1'b1;
			push_entry.data  = {16{8'h10}};
			push_entry.first = 1'b0;
			push_entry.last  = 1'b1;
		end else begin
			push_valid       = in_valid;
			push_entry.data  = blk;
			push_entry.first = !open_q;
			push_entry.last  = final_block && (cnt != 5'd16);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			pad_q  <= 1'b0;
		end else begin
			if (take) begin
				open_q <= !final_block;
				pad_q  <= final_block && (cnt == 5'd16);
			end else if (pad_q && push_ready) begin
				pad_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hdl/acbc_queue.sv -----
// ----------------------------------------------------------------------------
// acbc_queue: two-entry queue between front and round engine
// Lets the front keep taking blocks while the engine is busy.
// ----------------------------------------------------------------------------
`default_nettype none

module acbc_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push_valid,
	output logic                      push_ready,
	input  wire acbc_pkg::acbc_entry_t push_entry,
	output logic                      pop_valid,
	input  wire logic                 pop_ready,
	output acbc_pkg::acbc_entry_t     pop_entry
);

	acbc_pkg::acbc_entry_t slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_entry  = slot_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hdl/acbc_engine.sv -----
// ----------------------------------------------------------------------------
// acbc_engine: AES-256 round engine with CBC chaining
// One round per cycle; round keys are expanded on the fly alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module acbc_engine (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  q_valid,
	output logic                       q_ready,
	input  wire acbc_pkg::acbc_entry_t q_entry,
	input  wire logic [255:0]          key,
	input  wire logic [127:0]          iv,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [127:0]               out_data,
	output logic                       out_end
);

	acbc_pkg::acbc_eng_state_t state_q, state_nx;

	logic [127:0] st_q;
	logic [127:0] lo_q;
	logic [127:0] hi_q;
	logic [255:0] key_q;
	logic [127:0] chain_q;
	logic [3:0]   rnd_q;
	logic [7:0]   rcon_q;
	logic         end_q;
	logic         out_valid_q;

	logic         start;
	logic         load_out;
	logic         last_rnd;
	logic [255:0] kk;
	logic [127:0] cv;
	logic [127:0] ss;
	logic [3:0]   grp;
	logic [31:0]  w7;
	logic [31:0]  t;
	logic [31:0]  n0, n1, n2, n3;

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			acbc_pkg::ENG_IDLE: if (q_valid) state_nx = acbc_pkg::ENG_RUN;
			acbc_pkg::ENG_RUN:  if (last_rnd) state_nx = acbc_pkg::ENG_DONE;
			acbc_pkg::ENG_DONE: if (!out_valid_q || out_ready) state_nx = acbc_pkg::ENG_IDLE;
			default:            state_nx = acbc_pkg::ENG_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		q_ready  = 1'b0;
		load_out = 1'b0;
		case (state_q)
			acbc_pkg::ENG_IDLE: q_ready = 1'b1;
			acbc_pkg::ENG_DONE: load_out = !out_valid_q || out_ready;
			default:            ;
		endcase
	end

	assign start    = q_valid && q_ready;
	assign last_rnd = (state_q == acbc_pkg::ENG_RUN) && (rnd_q == 4'(acbc_pkg::ROUNDS));
	assign kk       = q_entry.first ? key : key_q;
	assign cv       = q_entry.first ? iv : chain_q;
	assign ss       = acbc_pkg::sub_shift(st_q);

	// next four schedule words from the eight-word window
	assign grp = rnd_q + 4'd1;
	assign w7  = hi_q[31:0];
	assign t   = grp[0] ? acbc_pkg::sub_word(w7)
	                    : acbc_pkg::sub_word({w7[23:0], w7[31:24]}) ^ {rcon_q, 24'h000000};
	assign n0  = lo_q[127:96] ^ t;
	assign n1  = lo_q[95:64] ^ n0;
	assign n2  = lo_q[63:32] ^ n1;
	assign n3  = lo_q[31:0] ^ n2;

	always_ff @(posedge clk) begin
		if (start) begin
			if (q_entry.first) begin
				key_q <= key;
			end
			st_q   <= q_entry.data ^ cv ^ kk[255:128];
			lo_q   <= kk[255:128];
			hi_q   <= kk[127:0];
			rcon_q <= 8'h01;
			end_q  <= q_entry.last;
		end else if (state_q == acbc_pkg::ENG_RUN) begin
			if (last_rnd) begin
				st_q <= ss ^ hi_q;
			end else begin
				st_q <= acbc_pkg::mix_cols(ss) ^ hi_q;
				lo_q <= hi_q;
				hi_q <= {n0, n1, n2, n3};
				if (!grp[0]) begin
					rcon_q <= acbc_pkg::xtime(rcon_q);
				end
			end
		end
		if (load_out) begin
			out_data <= st_q;
			out_end  <= end_q;
			chain_q  <= st_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= acbc_pkg::ENG_IDLE;
			rnd_q       <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (start) begin
				rnd_q <= 4'd1;
			end else if ((state_q == acbc_pkg::ENG_RUN) && !last_rnd) begin
				rnd_q <= rnd_q + 4'd1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTH
	a_rnd_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == acbc_pkg::ENG_RUN) |-> (rnd_q >= 4'd1 && rnd_q <= 4'd14))
		else $error("round count out of range");
	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (state_q == acbc_pkg::ENG_RUN && rnd_q == 4'd1))
		else $error("accepted block did not start round one");
	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (out_valid_q && state_q == acbc_pkg::ENG_IDLE))
		else $error("finished block not presented");
	a_busy_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != acbc_pkg::ENG_IDLE) |-> !q_ready)
		else $error("engine took a block while busy");
`endif

endmodule

`default_nettype wire

// ----- verif/aes256_cbc_encrypt_pkcs7_unit_tb.sv -----
// ----------------------------------------------------------------------------
// aes256_cbc_encrypt_pkcs7_unit_tb: self-checking bench for the CBC encrypt unit
// Runs a directed table followed by random messages under several key/IV
// settings. Each result is compared against an in-bench AES-256 CBC/PKCS#7
// predictor. Both channels idle at random, and there is one long output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module aes256_cbc_encrypt_pkcs7_unit_tb;

	// unused indexes of the configuration port
	localparam logic [2:0] REG_SPARE6  = 3'd6;
	localparam logic [2:0] REG_SPARE7  = 3'd7;

	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES   = 40;
	localparam int unsigned LONG_HOLD      = 300;

	// S-box, entry x at bits [2047-8x -: 8]
	localparam logic [2047:0] SUBST_LUT = {
		128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
		128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
		128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
		128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
		128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
		128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
		128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
		128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
	};

	typedef struct {
		logic [63:0] hi;
		logic [63:0] lo;
		logic        last;
	} cipher_rec_t;

	// one row of the directed table; chk marks a typed-in first result
	typedef struct {
		logic [63:0]  hi;
		logic [63:0]  lo;
		logic         fin;
		logic [4:0]   vb;
		logic         chk;
		logic [127:0] want;
	} plain_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write = 1'b0;
	logic [2:0]  cfg_index = acbc_pkg::REG_KEY0;
	logic [63:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [63:0] plain_high = '0;
	logic [63:0] plain_low = '0;
	logic        final_block = 1'b0;
	logic [4:0]  valid_bytes = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] cipher_high;
	logic [63:0] cipher_low;
	logic        message_end;

	aes256_cbc_encrypt_pkcs7_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.plain_high  (plain_high),
		.plain_low   (plain_low),
		.final_block (final_block),
		.valid_bytes (valid_bytes),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.cipher_high (cipher_high),
		.cipher_low  (cipher_low),
		.message_end (message_end)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor state: shadow registers, chain, message flag, round keys
	logic [63:0]  key_shadow [4];
	logic [127:0] iv_shadow = '0;
	logic [127:0] chain_reg = '0;
	logic         msg_active = 1'b0;
	logic [127:0] rk_sched [15];

	cipher_rec_t  expected_cipher_q [$];
	plain_row_t   plain_table [$];

	int unsigned errors = 0;
	int unsigned n_items = 0;
	int unsigned n_results = 0;
	int unsigned n_msgs = 0;
	int unsigned n_settings = 0;
	int unsigned n_long_pad = 0;
	bit          quiet = 1'b0;    // no idling on either side
	bit          hold_req = 1'b0; // ask the receiver for one long stall

	function automatic logic [7:0] subst(input logic [7:0] x);
		return SUBST_LUT[2047 - 8 * int'(x) -: 8];
	endfunction

	function automatic logic [7:0] dbl(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] subst_word(input logic [31:0] w);
		return {subst(w[31:24]), subst(w[23:16]), subst(w[15:8]), subst(w[7:0])};
	endfunction

	// SubBytes plus ShiftRows; byte j at bits [127-8j -: 8]
	function automatic logic [127:0] byte_sub_shift(input logic [127:0] s);
		logic [127:0] t;
		int           src;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				src = r + 4 * ((c + r) & 3);
				t[127 - 8 * (r + 4 * c) -: 8] = subst(s[127 - 8 * src -: 8]);
			end
		end
		return t;
	endfunction

	function automatic logic [127:0] column_mix(input logic [127:0] s);
		logic [127:0] t;
		logic [7:0]   b0, b1, b2, b3, sum;
		for (int c = 0; c < 4; c++) begin
			b0  = s[127 - 32 * c -: 8];
			b1  = s[119 - 32 * c -: 8];
			b2  = s[111 - 32 * c -: 8];
			b3  = s[103 - 32 * c -: 8];
			sum = b0 ^ b1 ^ b2 ^ b3;
			t[127 - 32 * c -: 8] = b0 ^ sum ^ dbl(b0 ^ b1);
			t[119 - 32 * c -: 8] = b1 ^ sum ^ dbl(b1 ^ b2);
			t[111 - 32 * c -: 8] = b2 ^ sum ^ dbl(b2 ^ b3);
			t[103 - 32 * c -: 8] = b3 ^ sum ^ dbl(b3 ^ b0);
		end
		return t;
	endfunction

	function automatic logic [127:0] aes256_encipher(input logic [127:0] blk);
		logic [127:0] s;
		s = blk ^ rk_sched[0];
		for (int r = 1; r < 14; r++)
			s = column_mix(byte_sub_shift(s)) ^ rk_sched[r];
		return byte_sub_shift(s) ^ rk_sched[14];
	endfunction

	// FIPS-197 AES-256 schedule from the key shadow registers
	task automatic expand_round_keys();
		logic [31:0] w [60];
		logic [31:0] t;
		logic [7:0]  rc;
		rc = 8'h01;
		for (int i = 0; i < 8; i++)
			w[i] = i[0] ? key_shadow[i >> 1][31:0] : key_shadow[i >> 1][63:32];
		for (int i = 8; i < 60; i++) begin
			t = w[i - 1];
			if ((i & 7) == 0) begin
				t  = subst_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
				rc = dbl(rc);
			end else if ((i & 7) == 4) begin
				t = subst_word(t);
			end
			w[i] = w[i - 8] ^ t;
		end
		for (int r = 0; r < 15; r++)
			rk_sched[r] = {w[4 * r], w[4 * r + 1], w[4 * r + 2], w[4 * r + 3]};
	endtask

	// chain one block through the cipher and queue its ciphertext
	task automatic chain_and_queue(input logic [127:0] blk, input logic last);
		cipher_rec_t rec;
		chain_reg = aes256_encipher(blk ^ chain_reg);
		rec.hi    = chain_reg[127:64];
		rec.lo    = chain_reg[63:0];
		rec.last  = last;
		expected_cipher_q.push_back(rec);
	endtask

	// one accepted plaintext block: open the message, pad, encrypt
	task automatic cbc_encrypt_item(input logic [63:0] hi, input logic [63:0] lo,
	                                input logic fin, input logic [4:0] vb);
		logic [127:0] blk;
		int           nv;
		if (!msg_active) begin
			expand_round_keys();
			chain_reg  = iv_shadow;
			msg_active = 1'b1;
		end
		blk = {hi, lo};
		if (!fin) begin
			chain_and_queue(blk, 1'b0);
		end else begin
			msg_active = 1'b0;
			n_msgs++;
			nv = (vb > 16) ? 16 : int'(vb);
			if (nv < 16) begin
				for (int j = nv; j < 16; j++)
					blk[127 - 8 * j -: 8] = 8'(16 - nv);
				chain_and_queue(blk, 1'b1);
			end else begin
				// full final block: trailing pad block carries the end mark
				n_long_pad++;
				chain_and_queue(blk, 1'b0);
				chain_and_queue({16{8'h10}}, 1'b1);
			end
		end
	endtask

	// write all six registers, then poke the unused indexes with junk
	task automatic load_settings(input logic [63:0] k0, input logic [63:0] k1,
	                             input logic [63:0] k2, input logic [63:0] k3,
	                             input logic [63:0] ivh, input logic [63:0] ivl);
		logic [63:0] vals [8];
		vals = '{k0, k1, k2, k3, ivh, ivl, {$urandom, $urandom}, {$urandom, $urandom}};
		for (int i = 0; i < 8; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data  <= vals[i];
			@(posedge clk);
			case (3'(i))
				acbc_pkg::REG_KEY0, acbc_pkg::REG_KEY1,
				acbc_pkg::REG_KEY2, acbc_pkg::REG_KEY3: key_shadow[i] = vals[i];
				acbc_pkg::REG_IV_HIGH: iv_shadow[127:64] = vals[i];
				acbc_pkg::REG_IV_LOW:  iv_shadow[63:0]   = vals[i];
				REG_SPARE6, REG_SPARE7: ; // ignored by the unit
				default: ;
			endcase
		end
		cfg_write <= 1'b0;
		@(posedge clk);
		n_settings++;
	endtask

	// drop valid and wait until every queued result is back, plus engine time
	task automatic wait_quiescent();
		in_valid <= 1'b0;
		while (expected_cipher_q.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// offer one block; hold it until the transfer, then predict
	task automatic send_block(input logic [63:0] hi, input logic [63:0] lo,
	                          input logic fin, input logic [4:0] vb,
	                          input logic chk, input logic [127:0] want);
		int base;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		plain_high  <= hi;
		plain_low   <= lo;
		final_block <= fin;
		valid_bytes <= vb;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		n_items++;
		base = expected_cipher_q.size();
		cbc_encrypt_item(hi, lo, fin, vb);
		if (chk) begin
			expected_cipher_q[base].hi = want[127:64];
			expected_cipher_q[base].lo = want[63:0];
		end
	endtask

	function automatic logic [63:0] rand_word();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// random message: mostly short, full blocks then a final with any count
	task automatic send_message();
		int          len;
		logic [4:0]  vb;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 3);
		for (int b = 0; b < len - 1; b++)
			send_block(rand_word(), rand_word(), 1'b0, 5'($urandom_range(0, 31)), 1'b0, '0);
		case ($urandom_range(0, 3))
			0:       vb = 5'd16;
			1:       vb = 5'($urandom_range(17, 31));
			default: vb = 5'($urandom_range(0, 15));
		endcase
		send_block(rand_word(), rand_word(), 1'b1, vb, 1'b0, '0);
	endtask

	task automatic add_row(input logic [63:0] hi, input logic [63:0] lo, input logic fin,
	                       input logic [4:0] vb, input logic chk, input logic [127:0] want);
		plain_row_t row;
		row = '{hi, lo, fin, vb, chk, want};
		plain_table.push_back(row);
	endtask

	// ------------------------------------------------------------------
	// Stimulus: directed table under the FIPS key, then random phases
	// ------------------------------------------------------------------
	initial begin
		int unsigned sent_before;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		load_settings(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
		              64'h1011121314151617, 64'h18191a1b1c1d1e1f, '0, '0);

		// FIPS-197 AES-256 vector: with a zero IV the first CBC block is plain AES
		add_row(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0, 5'd0, 1'b1,
		        128'h8ea2b7ca516745bfeafc49904b496089);
		add_row('1, '1, 1'b0, 5'd31, 1'b0, '0);          // count ignored mid-message
		add_row('0, '0, 1'b1, 5'd0, 1'b0, '0);           // empty final: all pad
		add_row('1, '1, 1'b1, 5'd16, 1'b0, '0);          // full final: extra pad block
		add_row('1, '0, 1'b1, 5'd31, 1'b0, '0);          // oversized count saturates
		add_row('0, '1, 1'b1, 5'd17, 1'b0, '0);
		add_row(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b1, 5'd1, 1'b0, '0);
		add_row(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b1, 5'd8, 1'b0, '0);
		add_row('1, '1, 1'b1, 5'd15, 1'b0, '0);          // one pad byte
		add_row(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0, 5'd5, 1'b0, '0);
		add_row(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0, 5'd16, 1'b0, '0);
		add_row(64'hdeadbeefcafef00d, 64'h0badc0de12345678, 1'b1, 5'd7, 1'b0, '0);
		add_row('0, '0, 1'b1, 5'd16, 1'b0, '0);
		foreach (plain_table[i])
			send_block(plain_table[i].hi, plain_table[i].lo, plain_table[i].fin,
			           plain_table[i].vb, plain_table[i].chk, plain_table[i].want);
		wait_quiescent();

		// settings: all ones, all zeros, then random ones; last phase runs flat out
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: load_settings('1, '1, '1, '1, '1, '1);
				1: load_settings('0, '0, '0, '0, '0, '0);
				default: load_settings(rand_word(), rand_word(), rand_word(), rand_word(),
				                       rand_word(), rand_word());
			endcase
			if (ph == 2)
				hold_req = 1'b1;
			if (ph == 4)
				quiet = 1'b1;
			sent_before = n_items;
			while (n_items - sent_before < 80)
				send_message();
			wait_quiescent();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d blocks in %0d messages under %0d key/IV settings, %0d results,",
		         n_items, n_msgs, n_settings, n_results);
		$display("  %0d full final blocks with a trailing pad block, plus a long output stall.",
		         n_long_pad);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// ------------------------------------------------------------------
	// Receiver: random stall bursts, one long hold, none in the last phase
	// ------------------------------------------------------------------
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				// hold long enough for the queue to fill and in_ready to drop
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
				out_ready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Checker: compare each output transfer with the oldest expectation
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		cipher_rec_t exp_rec;
		if (arst_n && out_valid && out_ready) begin
			n_results++;
			if (expected_cipher_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result %h_%h end %b", $time,
				         cipher_high, cipher_low, message_end);
			end else begin
				exp_rec = expected_cipher_q.pop_front();
				if (cipher_high !== exp_rec.hi) begin
					errors++;
					$display("%0t: cipher_high expected %h actual %h", $time,
					         exp_rec.hi, cipher_high);
				end
				if (cipher_low !== exp_rec.lo) begin
					errors++;
					$display("%0t: cipher_low expected %h actual %h", $time,
					         exp_rec.lo, cipher_low);
				end
				if (message_end !== exp_rec.last) begin
					errors++;
					$display("%0t: message_end expected %b actual %b", $time,
					         exp_rec.last, message_end);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: abort when neither channel transfers for too long
	// ------------------------------------------------------------------
	int unsigned stuck_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write) begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("%0t: timeout, %0d results still expected", $time,
				         expected_cipher_q.size());
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

endmodule

`default_nettype wire
